### rtl/brbw_pkg.sv
package brbw_pkg;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned WM_W   = 11;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_MAX_CHUNK = 1'b0,
    REG_WATERMARK = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0] max_chunk;
    logic [WM_W-1:0]  watermark;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              rdata_valid;
    logic              end_of_run;
    logic              status;
    logic [LEN_W-1:0]  moved;
    logic              ready_event;
    logic              space_event;
  } res_t;

endpackage

### rtl/brbw_store.sv
module brbw_store #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [brbw_pkg::DATA_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [brbw_pkg::DATA_W-1:0]  rdata_o
);
  import brbw_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/brbw_ctrl.sv
module brbw_ctrl #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned CHUNK_LIMIT = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brbw_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [brbw_pkg::LEN_W-1:0]   length_i,
  input  logic [brbw_pkg::DATA_W-1:0]  data_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output brbw_pkg::res_t               res_o,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [brbw_pkg::DATA_W-1:0]  mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  logic [brbw_pkg::DATA_W-1:0]  mem_rdata_i
);
  import brbw_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > WM_W) ? FW : WM_W;
  localparam logic [LEN_W-1:0] LIM = LEN_W'(CHUNK_LIMIT);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic             rej_q, rej_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] n_q, n_d;
  logic             space_q, space_d;
  logic             p1_q, p1_d;
  logic             p1_last_q, p1_last_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic [LEN_W-1:0] lim;
  logic             reject, rej_now, out_free, busy, acc_in, is_wr, is_rd;
  logic             store, issue, load_p1;
  logic [LEN_W-1:0] acc_new, n;
  logic [FW-1:0]    fill_wr, fill_rd;
  logic [CW-1:0]    wm;

  always_comb begin
    lim      = (cfg_i.max_chunk < LIM) ? cfg_i.max_chunk : LIM;
    reject   = length_i > lim;
    out_free = !out_valid_q || out_ready_i;
    busy     = (rem_q != '0) || p1_q;
    is_wr    = cmd_e'(cmd_i) == CMD_WRITE;
    is_rd    = cmd_e'(cmd_i) == CMD_READ;
    acc_in   = in_valid_i && in_ready_o;
    rej_now  = rej_q || reject;
    store    = acc_in && is_wr && !rej_now && (acc_q < length_i) && (fill_q != FULL);
    acc_new  = acc_q + LEN_W'(store);
    fill_wr  = fill_q + FW'(store);
    n        = (CW'(length_i) < CW'(fill_q)) ? length_i : LEN_W'(fill_q);
    fill_rd  = fill_q - FW'(n);
    wm       = CW'(cfg_i.watermark);
    load_p1  = p1_q && out_free;
    issue    = (rem_q != '0) && (!p1_q || load_p1);
  end

  assign in_ready_o  = !busy && out_free;
  assign mem_we_o    = store;
  assign mem_waddr_o = wptr_q;
  assign mem_wdata_o = data_i;
  assign mem_re_o    = issue;
  assign mem_raddr_o = rptr_q;

  always_comb begin
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    rej_d       = rej_q;
    rem_d       = rem_q;
    n_d         = n_q;
    space_d     = space_q;
    p1_d        = p1_q;
    p1_last_d   = p1_last_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (store) begin
      wptr_d = (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
    end

    if (issue) begin
      rptr_d    = (rptr_q == LAST_ADDR) ? '0 : rptr_q + AW'(1);
      rem_d     = rem_q - LEN_W'(1);
      p1_last_d = rem_q == LEN_W'(1);
    end

    priority if (issue) begin
      p1_d = 1'b1;
    end else if (load_p1) begin
      p1_d = 1'b0;
    end else begin
      p1_d = p1_q;
    end

    if (load_p1) begin
      out_valid_d       = 1'b1;
      res_d.rdata       = mem_rdata_i;
      res_d.rdata_valid = 1'b1;
      res_d.end_of_run  = p1_last_q;
      res_d.status      = 1'b0;
      res_d.moved       = p1_last_q ? n_q : '0;
      res_d.ready_event = 1'b0;
      res_d.space_event = p1_last_q && space_q;
    end

    if (acc_in && is_wr) begin
      fill_d = fill_wr;
      acc_d  = last_i ? '0 : acc_new;
      rej_d  = last_i ? 1'b0 : rej_now;
      if (last_i) begin
        out_valid_d       = 1'b1;
        res_d.rdata       = '0;
        res_d.rdata_valid = 1'b0;
        res_d.end_of_run  = 1'b1;
        res_d.status      = rej_now;
        res_d.moved       = rej_now ? '0 : acc_new;
        res_d.ready_event = !rej_now && (CW'(fill_wr) > wm);
        res_d.space_event = 1'b0;
      end
    end

    if (acc_in && is_rd) begin
      out_valid_d       = 1'b0;
      res_d.rdata       = '0;
      res_d.rdata_valid = 1'b0;
      res_d.end_of_run  = 1'b1;
      res_d.moved       = '0;
      res_d.ready_event = 1'b0;
      priority if (reject) begin
        out_valid_d       = 1'b1;
        res_d.status      = 1'b1;
        res_d.space_event = 1'b0;
      end else if (n == '0) begin
        out_valid_d       = 1'b1;
        res_d.status      = 1'b0;
        res_d.space_event = CW'(fill_q) < wm;
      end else begin
        fill_d  = fill_rd;
        rem_d   = n;
        n_d     = n;
        space_d = CW'(fill_rd) < wm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      fill_q      <= '0;
      acc_q       <= '0;
      rej_q       <= 1'b0;
      rem_q       <= '0;
      n_q         <= '0;
      space_q     <= 1'b0;
      p1_q        <= 1'b0;
      p1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      fill_q      <= fill_d;
      acc_q       <= acc_d;
      rej_q       <= rej_d;
      rem_q       <= rem_d;
      n_q         <= n_d;
      space_q     <= space_d;
      p1_q        <= p1_d;
      p1_last_q   <= p1_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/byte_ring_buffer_watermark_top.sv
// Write bytes: one transfer per cycle unless a read is busy or the result stalls; a last byte
// gives its result in the next cycle. Read requests: first byte via the remaining count, the
// store's read register and the result register, then one byte per cycle unless stalled, set
// by the single read port of the byte store; next item taken as the final byte transfers.
// Reset (rst_ni low, asynchronous) empties the buffer and restores max_chunk 64,
// watermark 256; store contents are left as they are.
module byte_ring_buffer_watermark_top #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned CHUNK_LIMIT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [brbw_pkg::WM_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [brbw_pkg::LEN_W-1:0]   length_i,
  input  logic [brbw_pkg::DATA_W-1:0]  data_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [brbw_pkg::DATA_W-1:0]  rdata_o,
  output logic                         rdata_valid_o,
  output logic                         end_of_run_o,
  output logic                         status_o,
  output logic [brbw_pkg::LEN_W-1:0]   moved_o,
  output logic                         ready_event_o,
  output logic                         space_event_o
);
  import brbw_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  cfg_t  cfg_q;
  res_t  res;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_chunk <= LEN_W'(64);
      cfg_q.watermark <= WM_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_CHUNK: cfg_q.max_chunk <= cfg_data_i[LEN_W-1:0];
        REG_WATERMARK: cfg_q.watermark <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brbw_ctrl #(
    .DEPTH       (DEPTH),
    .CHUNK_LIMIT (CHUNK_LIMIT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .length_i    (length_i),
    .data_i      (data_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  brbw_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rdata_o       = res.rdata;
  assign rdata_valid_o = res.rdata_valid;
  assign end_of_run_o  = res.end_of_run;
  assign status_o      = res.status;
  assign moved_o       = res.moved;
  assign ready_event_o = res.ready_event;
  assign space_event_o = res.space_event;

endmodule

### rtl/brbw_checker.sv
module brbw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [brbw_pkg::DATA_W-1:0]  rdata_o,
  input logic                         rdata_valid_o,
  input logic                         end_of_run_o,
  input logic                         status_o,
  input logic [brbw_pkg::LEN_W-1:0]   moved_o,
  input logic                         ready_event_o,
  input logic                         space_event_o
);
  import brbw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rdata_valid_o |-> rdata_o == '0)
    else $error("rdata not zero without read byte");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> end_of_run_o && moved_o == '0 &&
      !rdata_valid_o && !ready_event_o && !space_event_o)
    else $error("malformed rejection result");

  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_run_o |-> rdata_valid_o && moved_o == '0 &&
      !ready_event_o && !space_event_o)
    else $error("malformed mid-run result");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ready_event_o && space_event_o))
    else $error("both events on one result");

endmodule

bind byte_ring_buffer_watermark_top brbw_checker u_brbw_checker (.*);
